@@ src/assert_macros.svh @@
// assertion helpers used by the column fill core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define RMCF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define RMCF_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RMCF_ASSERT(label, clk, rst, prop, msg)
`define RMCF_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ src/rmcf_pkg.sv @@
package rmcf_pkg;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 10;
  localparam int CNT_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int MAX_QUERY = 63;
  localparam int MAX_REF   = 1024;

  localparam logic [CHAR_W-1:0] UPCASE_MASK = 8'hDF;

  // request commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_LEFT = 2'd1;
  localparam logic [1:0] DIR_DIAG = 2'd2;
  localparam logic [1:0] DIR_JUMP = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MATCH     = 3'd0;
  localparam logic [2:0] REG_MISMATCH  = 3'd1;
  localparam logic [2:0] REG_GAP       = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_QLEN      = 3'd4;

  typedef struct packed {
    logic [1:0]       dir;
    logic [ROW_W-1:0] jrow;
    logic [COL_W-1:0] jcol;
  } jump_info_t;

endpackage

@@ src/rmcf_query_mem.sv @@
module rmcf_query_mem
  import rmcf_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ROW_W-1:0]  rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [0:MAX_QUERY-1];

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr < ROW_W'(MAX_QUERY))) begin
      mem[wr_addr] <= wr_data;
    end
    // address past the store only comes up on the spare read after the last row
    if (rd_en && (rd_addr < ROW_W'(MAX_QUERY))) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/rmcf_col_mem.sv @@
module rmcf_col_mem
  import rmcf_pkg::*;
#(
  parameter int SB = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_addr,
  input  logic [SB-1:0]    wr_data,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_addr,
  output logic [SB-1:0]    rd_data
);

  localparam int DEPTH = MAX_QUERY + 1;

  logic [SB-1:0]    mem [0:DEPTH-1];
  logic [DEPTH-1:0] valid;
  logic [SB-1:0]    data_q;
  logic             valid_q;

  // valid bits make a cleared entry read as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q  <= mem[rd_addr];
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? data_q : '0;

endmodule

@@ src/rmcf_cell.sv @@
module rmcf_cell
  import rmcf_pkg::*;
#(
  parameter int SB = 16
) (
  input  logic [SB-1:0]     prev_diag,
  input  logic [SB-1:0]     prev_left,
  input  logic [SB-1:0]     cur_up,
  input  logic [SB-1:0]     cur_jump,
  input  logic [CHAR_W-1:0] query_char,
  input  logic [CHAR_W-1:0] ref_char,
  input  logic [3:0]        match_score,
  input  logic [4:0]        mismatch_score,
  input  logic [4:0]        gap_score,
  input  jump_info_t        row0_info,
  output logic [SB-1:0]     cell_score,
  output jump_info_t        cell_info
);

  localparam int EW = SB + 2;

  logic signed [EW-1:0] sub, gap, diag, up, left, jmp, mx;

  always_comb begin
    if ((query_char & UPCASE_MASK) == ref_char) begin
      sub = signed'({{(EW-4){1'b0}}, match_score});
    end else begin
      sub = signed'({{(EW-5){mismatch_score[4]}}, mismatch_score});
    end
    gap  = signed'({{(EW-5){gap_score[4]}}, gap_score});
    diag = signed'({2'b00, prev_diag}) + sub;
    up   = signed'({2'b00, cur_up}) + gap;
    left = signed'({2'b00, prev_left}) + gap;
    jmp  = signed'({2'b00, cur_jump});

    mx = diag;
    if (up > mx) mx = up;
    if (left > mx) mx = left;
    if (jmp > mx) mx = jmp;

    // ties: diagonal, then jump row, then up, then left
    cell_info = '0;
    if (diag == mx) begin
      cell_info.dir = DIR_DIAG;
    end else if (jmp == mx) begin
      cell_info = row0_info;
    end else if (up == mx) begin
      cell_info.dir = DIR_UP;
    end else begin
      cell_info.dir = DIR_LEFT;
    end

    // never below the jump row score, so only the top needs a clamp
    if (mx[EW-1:SB] != 2'b00) begin
      cell_score = '1;
    end else begin
      cell_score = mx[SB-1:0];
    end
  end

endmodule

@@ src/repeat_match_column_fill_core.sv @@
// reference request: busy through the scan, decide and fill states (len = query_length); the next one waits until idle;
//   row 0 result registered from the decide state, rows 1..len on the following cycles
// the single read port of the column memory is walked twice per column (max scan, fill)
// start and load requests leave the block idle and give no result
// rst is synchronous: config back to defaults, column store reads as zero, query store kept
// results are one-cycle strobes; the receiver cannot stall
`include "assert_macros.svh"

module repeat_match_column_fill_core
  import rmcf_pkg::*;
#(
  parameter int SCORE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // request side
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [ROW_W-1:0]      query_index,
  input  logic [CHAR_W-1:0]     char_value,
  // result side
  output logic                  strobe,
  output logic [ROW_W-1:0]      row,
  output logic [SCORE_BITS-1:0] score,
  output logic [1:0]            direction,
  output logic [ROW_W-1:0]      jump_row,
  output logic [COL_W-1:0]      jump_col,
  output logic                  last
);

  localparam int SB = SCORE_BITS;
  localparam int EW = SB + 2;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_FILL   = 2'd3;

  // configuration registers
  logic [3:0]       match_score;
  logic [4:0]       mismatch_score;
  logic [4:0]       gap_score;
  logic [7:0]       jump_threshold;
  logic [ROW_W-1:0] query_length;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_score    <= 4'd4;
      mismatch_score <= 5'h1C;
      gap_score      <= 5'h1C;
      jump_threshold <= 8'd20;
      query_length   <= 6'd1;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_MATCH:     match_score    <= pwdata[3:0];
        REG_MISMATCH:  mismatch_score <= pwdata[4:0];
        REG_GAP:       gap_score      <= pwdata[4:0];
        REG_THRESHOLD: jump_threshold <= pwdata[7:0];
        REG_QLEN:      query_length   <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MATCH:     prdata = {28'b0, match_score};
      REG_MISMATCH:  prdata = {27'b0, mismatch_score};
      REG_GAP:       prdata = {27'b0, gap_score};
      REG_THRESHOLD: prdata = {24'b0, jump_threshold};
      REG_QLEN:      prdata = {26'b0, query_length};
      default:       prdata = '0;
    endcase
  end

  // sequencer registers
  logic [1:0]       state;
  logic [ROW_W-1:0] scan_cnt;      // next row whose read goes out during the scan
  logic             scan_issued;   // every read of the scan has gone out
  logic             ret_vld;       // scan read data arrives this cycle
  logic [ROW_W-1:0] ret_row;
  logic [ROW_W-1:0] len_q;
  logic [ROW_W-1:0] fill_row;
  logic [CNT_W-1:0] col_counter;
  jump_info_t       row0_info;

  // datapath registers
  logic [SB-1:0]     max_val;
  logic [ROW_W-1:0]  max_row;
  logic [SB-1:0]     prev0;
  logic [SB-1:0]     prev_im1;     // previous column, row above the current one
  logic [SB-1:0]     cur_prev;     // current column, row above the current one
  logic [SB-1:0]     row0_score;
  logic [CHAR_W-1:0] ref_char;

  logic accept;
  logic step_ok;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign step_ok = (command == CMD_STEP) && (col_counter < CNT_W'(MAX_REF));

  // memory ports
  logic             col_clear;
  logic             col_wr_en;
  logic [ROW_W-1:0] col_wr_addr;
  logic [SB-1:0]    col_wr_data;
  logic             col_rd_en;
  logic [ROW_W-1:0] col_rd_addr;
  logic [SB-1:0]    col_rd_data;
  logic             q_wr_en;
  logic             q_rd_en;
  logic [ROW_W-1:0] q_rd_addr;
  logic [CHAR_W-1:0] q_rd_data;

  // row 0 decision
  logic signed [EW-1:0] best;
  logic                 take_jump;
  logic [SB-1:0]        cur0;
  jump_info_t           decide_info;

  always_comb begin
    best      = signed'({2'b00, max_val}) - signed'({{(EW-8){1'b0}}, jump_threshold});
    take_jump = best >= signed'({2'b00, prev0});
    if (take_jump) begin
      cur0             = best[SB-1:0];
      decide_info.dir  = DIR_JUMP;
      decide_info.jrow = max_row;
      decide_info.jcol = col_counter[COL_W-1:0];
    end else begin
      cur0        = prev0;
      decide_info = '0;
      decide_info.dir = DIR_LEFT;
    end
  end

  // cell for rows 1..len
  logic [SB-1:0] cell_score;
  jump_info_t    cell_info;

  rmcf_cell #(
    .SB(SB)
  ) u_cell (
    .prev_diag      (prev_im1),
    .prev_left      (col_rd_data),
    .cur_up         (cur_prev),
    .cur_jump       (row0_score),
    .query_char     (q_rd_data),
    .ref_char       (ref_char),
    .match_score    (match_score),
    .mismatch_score (mismatch_score),
    .gap_score      (gap_score),
    .row0_info      (row0_info),
    .cell_score     (cell_score),
    .cell_info      (cell_info)
  );

  // memory access per state: the fill reads row i+1 while writing row i back
  always_comb begin
    col_clear   = accept && (command == CMD_START);
    q_wr_en     = accept && (command == CMD_LOAD);
    col_wr_en   = 1'b0;
    col_wr_addr = '0;
    col_wr_data = '0;
    col_rd_en   = 1'b0;
    col_rd_addr = '0;
    q_rd_en     = 1'b0;
    q_rd_addr   = '0;
    case (state)
      ST_SCAN: begin
        col_rd_en   = !scan_issued;
        col_rd_addr = scan_cnt;
      end
      ST_DECIDE: begin
        col_wr_en   = 1'b1;
        col_wr_data = cur0;
        col_rd_en   = 1'b1;
        col_rd_addr = ROW_W'(1);
        q_rd_en     = 1'b1;
      end
      ST_FILL: begin
        col_wr_en   = 1'b1;
        col_wr_addr = fill_row;
        col_wr_data = cell_score;
        col_rd_en   = 1'b1;
        col_rd_addr = fill_row + ROW_W'(1);
        q_rd_en     = 1'b1;
        q_rd_addr   = fill_row;
      end
      default: ;
    endcase
  end

  rmcf_col_mem #(
    .SB(SB)
  ) u_col_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (col_clear),
    .wr_en   (col_wr_en),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_en   (col_rd_en),
    .rd_addr (col_rd_addr),
    .rd_data (col_rd_data)
  );

  rmcf_query_mem u_query_mem (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (query_index),
    .wr_data (char_value),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_cnt    <= '0;
      scan_issued <= 1'b0;
      ret_vld     <= 1'b0;
      fill_row    <= '0;
      col_counter <= '0;
      row0_info   <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe  <= 1'b0;
      ret_vld <= (state == ST_SCAN) && !scan_issued;
      case (state)
        ST_IDLE: begin
          if (accept && (command == CMD_START)) begin
            col_counter <= '0;
            row0_info   <= '0;
          end
          if (accept && step_ok) begin
            state       <= ST_SCAN;
            scan_cnt    <= '0;
            scan_issued <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!scan_issued) begin
            scan_cnt <= scan_cnt + ROW_W'(1);
            if (scan_cnt == len_q) scan_issued <= 1'b1;
          end
          if (ret_vld && (ret_row == len_q)) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          strobe      <= 1'b1;
          row0_info   <= decide_info;
          col_counter <= col_counter + CNT_W'(1);
          fill_row    <= ROW_W'(1);
          state       <= (len_q == '0) ? ST_IDLE : ST_FILL;
        end
        ST_FILL: begin
          strobe <= 1'b1;
          if (fill_row == len_q) begin
            state <= ST_IDLE;
          end else begin
            fill_row <= fill_row + ROW_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    ret_row <= scan_cnt;
    if (accept && step_ok) begin
      ref_char <= char_value & UPCASE_MASK;
      max_val  <= '0;
      max_row  <= '0;
      len_q    <= (query_length > ROW_W'(MAX_QUERY)) ? ROW_W'(MAX_QUERY) : query_length;
    end
    // running maximum, later rows win ties
    if ((state == ST_SCAN) && ret_vld) begin
      if (ret_row == '0) prev0 <= col_rd_data;
      if (col_rd_data >= max_val) begin
        max_val <= col_rd_data;
        max_row <= ret_row;
      end
    end
    case (state)
      ST_DECIDE: begin
        row0_score <= cur0;
        cur_prev   <= cur0;
        prev_im1   <= prev0;
        row        <= '0;
        score      <= cur0;
        direction  <= decide_info.dir;
        jump_row   <= decide_info.jrow;
        jump_col   <= decide_info.jcol;
        last       <= (len_q == '0);
      end
      ST_FILL: begin
        cur_prev  <= cell_score;
        prev_im1  <= col_rd_data;
        row       <= fill_row;
        score     <= cell_score;
        direction <= cell_info.dir;
        jump_row  <= cell_info.jrow;
        jump_col  <= cell_info.jcol;
        last      <= (fill_row == len_q);
      end
      default: ;
    endcase
  end

  // checks
  `RMCF_ASSERT(a_strobe_src, clk, rst, strobe |-> $past(state == ST_DECIDE || state == ST_FILL), "result without a decide or fill cycle")
  `RMCF_ASSERT(a_last_idle, clk, rst, (strobe && last) |-> !busy, "still busy after the last row")
  `RMCF_ASSERT(a_row_seq, clk, rst, (strobe && !last) |=> (strobe && (row == $past(row) + ROW_W'(1))), "rows not back to back")
  `RMCF_ASSERT_NEVER(a_col_clash, clk, rst, col_wr_en && col_rd_en && (col_wr_addr == col_rd_addr), "column read and write hit one row")

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmcf_pkg::*;

  // one request as queued for the driver
  typedef struct packed {
    logic [1:0]        cmd;
    logic [ROW_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              drain;  // hold back until every cell of earlier requests is out
  } request_t;

  // one matrix cell as the block should report it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [15:0]      score;
    logic [1:0]       dir;
    logic [ROW_W-1:0] jrow;
    logic [COL_W-1:0] jcol;
    logic             last;
  } cell_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SCORE_MAX    = 65535;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 2 * MAX_QUERY + 8;
  localparam int RANDOM_ITEMS = 250;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [4:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            command = CMD_START;
  logic [ROW_W-1:0]      query_index = '0;
  logic [CHAR_W-1:0]     char_value = '0;
  logic                  strobe;
  logic [ROW_W-1:0]      row;
  logic [15:0]           score;
  logic [1:0]            direction;
  logic [ROW_W-1:0]      jump_row;
  logic [COL_W-1:0]      jump_col;
  logic                  last;

  // register mirror
  logic [3:0]        cfg_match;
  logic signed [4:0] cfg_mismatch;
  logic signed [4:0] cfg_gap;
  logic [7:0]        cfg_thresh;
  logic [5:0]        cfg_qlen;

  // column engine mirror
  logic [CHAR_W-1:0] query_chars [0:MAX_QUERY-1];
  int                col_scores [0:MAX_QUERY];
  logic [CNT_W-1:0]  col_count;
  logic [1:0]        r0_dir;
  logic [ROW_W-1:0]  r0_jrow;
  logic [COL_W-1:0]  r0_jcol;

  cell_t    cells_due [$];
  request_t pending [$];

  logic took = 1'b0;  // request taken at the last rising edge
  bit   calm = 1'b0;  // no sender idling in the closing part
  int   idle_left = 0;
  int   quiet = 0;
  int   errors = 0;
  int   n_pushed = 0;
  int   n_accepted = 0;
  int   n_steps = 0;
  int   n_dropped = 0;
  int   n_loads = 0;
  int   n_starts = 0;
  int   n_unused = 0;
  int   n_cells = 0;
  int   n_jumps = 0;
  int   n_lefts = 0;
  int   n_writes = 0;

  repeat_match_column_fill_core i_dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // column predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp_score(int v);
    if (v > SCORE_MAX) return SCORE_MAX;
    if (v < 0) return 0;
    return v;
  endfunction

  // empty column store, as after reset or a start request
  function automatic void clear_columns();
    foreach (col_scores[k]) col_scores[k] = 0;
    col_count = '0;
    r0_dir    = DIR_UP;
    r0_jrow   = '0;
    r0_jcol   = '0;
  endfunction

  function automatic void push_cell(int r, int sc, logic [1:0] d, logic [ROW_W-1:0] jr,
                                    logic [COL_W-1:0] jc, bit fin);
    cell_t c;
    c.row   = ROW_W'(r);
    c.score = 16'(sc);
    c.dir   = d;
    // pointer fields only carry meaning on a jump
    c.jrow  = (d == DIR_JUMP) ? jr : '0;
    c.jcol  = (d == DIR_JUMP) ? jc : '0;
    c.last  = fin;
    if (d == DIR_JUMP) n_jumps++;
    else if (d == DIR_LEFT) n_lefts++;
    cells_due.push_back(c);
  endfunction

  // one reference character: the next column, row 0 first
  function automatic void fill_column(logic [CHAR_W-1:0] ch);
    int len, best, brow, gap, s, diag, up, lft, jmp, mx;
    int cur [0:MAX_QUERY];
    logic [CHAR_W-1:0] rc;
    logic [1:0] d;
    logic [ROW_W-1:0] jr;
    logic [COL_W-1:0] jc;
    if (col_count >= MAX_REF) begin
      // column limit reached since the last start
      n_dropped++;
      return;
    end
    len = (cfg_qlen > MAX_QUERY) ? MAX_QUERY : int'(cfg_qlen);
    gap = int'(cfg_gap);
    // previous column maximum, ties go to the highest row
    best = 0;
    brow = 0;
    for (int k = 0; k <= len; k++) begin
      if (k == 0 || col_scores[k] - int'(cfg_thresh) >= best) begin
        best = col_scores[k] - int'(cfg_thresh);
        brow = k;
      end
    end
    if (best >= col_scores[0]) begin
      cur[0]  = clamp_score(best);
      r0_dir  = DIR_JUMP;
      r0_jrow = ROW_W'(brow);
      r0_jcol = col_count[COL_W-1:0];
    end else begin
      cur[0]  = col_scores[0];
      r0_dir  = DIR_LEFT;
      r0_jrow = '0;
      r0_jcol = '0;
    end
    push_cell(0, cur[0], r0_dir, r0_jrow, r0_jcol, len == 0);
    rc = ch & UPCASE_MASK;
    for (int i = 1; i <= len; i++) begin
      s = ((query_chars[i-1] & UPCASE_MASK) == rc) ? int'(cfg_match) : int'(cfg_mismatch);
      diag = col_scores[i-1] + s;
      up   = cur[i-1] + gap;
      lft  = col_scores[i] + gap;
      jmp  = cur[0];
      mx = diag;
      if (up > mx) mx = up;
      if (lft > mx) mx = lft;
      if (jmp > mx) mx = jmp;
      jr = '0;
      jc = '0;
      // priority: diagonal, jump row copy, up, left
      if (diag == mx) begin
        d = DIR_DIAG;
      end else if (jmp == mx) begin
        d  = r0_dir;
        jr = r0_jrow;
        jc = r0_jcol;
      end else if (up == mx) begin
        d = DIR_UP;
      end else begin
        d = DIR_LEFT;
      end
      cur[i] = clamp_score(mx);
      push_cell(i, cur[i], d, jr, jc, i == len);
    end
    for (int i = 0; i <= len; i++) col_scores[i] = cur[i];
    col_count = col_count + 1'b1;
  endfunction

  function automatic void apply_request(logic [1:0] cmd, logic [ROW_W-1:0] idx,
                                        logic [CHAR_W-1:0] ch);
    case (cmd)
      CMD_START: begin
        n_starts++;
        clear_columns();
      end
      CMD_LOAD: begin
        n_loads++;
        // an index past the store is dropped
        if (idx < MAX_QUERY) query_chars[idx] = ch;
      end
      CMD_STEP: begin
        n_steps++;
        fill_column(ch);
      end
      default: begin
        n_unused++;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly dna letters in either case, sometimes any byte
  function automatic logic [CHAR_W-1:0] pick_base();
    logic [CHAR_W-1:0] bases [0:3];
    logic [CHAR_W-1:0] b;
    bases = '{"A", "C", "G", "T"};
    if ($urandom_range(0, 11) == 0) return CHAR_W'($urandom);
    b = bases[$urandom_range(0, 3)];
    if ($urandom_range(0, 2) == 0) b = b ^ 8'h20;
    return b;
  endfunction

  task automatic add_request(input logic [1:0] cmd, input logic [ROW_W-1:0] idx,
                             input logic [CHAR_W-1:0] ch, input bit drain);
    pending.push_back('{cmd, idx, ch, drain});
    n_pushed++;
  endtask

  // a well-formed alignment: usually a start, then reference characters, with some noise mixed in
  task automatic add_job(input int steps);
    if ($urandom_range(0, 4) != 0)
      add_request(CMD_START, ROW_W'($urandom), CHAR_W'($urandom), 1'b0);
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: add_request(CMD_UNUSED, ROW_W'($urandom), CHAR_W'($urandom), 1'b0);
          1: add_request(CMD_LOAD, ROW_W'(MAX_QUERY), CHAR_W'($urandom), 1'b0);
          2: add_request(CMD_LOAD, ROW_W'($urandom_range(0, MAX_QUERY - 1)), pick_base(), 1'b0);
          default: add_request(CMD_START, ROW_W'($urandom), CHAR_W'($urandom), 1'b0);
        endcase
      end
      add_request(CMD_STEP, ROW_W'($urandom), pick_base(),
                  s == 0 && $urandom_range(0, 3) == 0);
    end
  endtask

  // register write over the apb port, mirror updated up front since the block is idle
  task automatic write_reg(input logic [2:0] idx, input int value);
    logic [31:0] d;
    d = value;
    case (idx)
      REG_MATCH: begin
        d = d & 32'h0F;
        cfg_match = d[3:0];
      end
      REG_MISMATCH: begin
        d = d & 32'h1F;
        cfg_mismatch = d[4:0];
      end
      REG_GAP: begin
        d = d & 32'h1F;
        cfg_gap = d[4:0];
      end
      REG_THRESHOLD: begin
        d = d & 32'hFF;
        cfg_thresh = d[7:0];
      end
      default: begin
        d = d & 32'h3F;
        cfg_qlen = d[5:0];
      end
    endcase
    n_writes++;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait until every queued request is taken and every cell has come out
  task automatic settle();
    while (n_accepted != n_pushed || busy || cells_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one request at a time from the pending queue, changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    request_t r;
    bit offer;
    offer = 1'b0;
    // an offered request stays up until the block takes it
    if (!rst && !(start && !took)) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending.size() != 0 &&
                   !(pending[0].drain && (cells_due.size() != 0 || busy))) begin
        r = pending.pop_front();
        offer = 1'b1;
        // random idle burst after this request
        if (!calm && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 15);
      end
      if (offer) begin
        start       <= 1'b1;
        command     <= r.cmd;
        query_index <= r.idx;
        char_value  <= r.ch;
      end else begin
        // junk on the fields while nothing is offered
        start       <= 1'b0;
        command     <= 2'($urandom_range(0, 3));
        query_index <= ROW_W'($urandom);
        char_value  <= CHAR_W'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes requests into the predictor, checks cells, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_t want;
    took <= !rst && start && !busy;
    if (!rst) begin
      quiet++;
      // check cells before predicting a request taken on the same edge
      if (strobe) begin
        quiet = 0;
        if (cells_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected cell, row %0d score %0d", $time, row, score);
        end else begin
          want = cells_due.pop_front();
          check_field("row", 32'(want.row), 32'(row));
          check_field("score", 32'(want.score), 32'(score));
          check_field("direction", 32'(want.dir), 32'(direction));
          check_field("jump_row", 32'(want.jrow), 32'(jump_row));
          check_field("jump_col", 32'(want.jcol), 32'(jump_col));
          check_field("last", 32'(want.last), 32'(last));
          n_cells++;
        end
      end
      if (start && !busy) begin
        quiet = 0;
        n_accepted++;
        apply_request(command, query_index, char_value);
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int first_random;
    int qlen;
    int steps;
    // defaults after reset
    cfg_match    = 4'd4;
    cfg_mismatch = -5'sd4;
    cfg_gap      = -5'sd4;
    cfg_thresh   = 8'd20;
    cfg_qlen     = 6'd1;
    foreach (query_chars[k]) query_chars[k] = '0;
    clear_columns();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset settings, one query row
    add_request(CMD_LOAD, 6'd0, "a", 1'b0);
    add_request(CMD_LOAD, ROW_W'(MAX_QUERY), 8'hFF, 1'b0);  // past the store, dropped
    add_request(CMD_UNUSED, 6'd63, 8'hFF, 1'b0);
    add_request(CMD_STEP, 6'd0, "A", 1'b0);                 // equal once upper-cased
    add_request(CMD_STEP, 6'd0, 8'h00, 1'b0);
    add_request(CMD_STEP, 6'd0, 8'hFF, 1'b0);
    add_request(CMD_STEP, 6'd0, "a", 1'b1);                 // sender waits for all cells
    add_request(CMD_START, 6'd42, 8'h5A, 1'b0);
    add_request(CMD_STEP, 6'd0, "a", 1'b0);
    add_request(CMD_LOAD, 6'd62, 8'h00, 1'b0);
    add_request(CMD_LOAD, 6'd0, 8'hFF, 1'b0);
    add_request(CMD_STEP, 6'd21, 8'hDF, 1'b0);              // matches the 0xff query char once both are masked
    add_request(CMD_STEP, 6'd0, 8'h7F, 1'b0);
    add_request(CMD_START, 6'd0, 8'h00, 1'b0);
    add_request(CMD_STEP, 6'd0, 8'hFF, 1'b0);
    settle();

    // zero query length: row 0 alone, always last
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_QLEN, 0);
    add_request(CMD_STEP, 6'd0, "G", 1'b0);
    add_request(CMD_STEP, 6'd63, "c", 1'b0);
    add_request(CMD_START, 6'd0, 8'h00, 1'b0);
    add_request(CMD_STEP, 6'd0, "T", 1'b0);
    settle();

    // random part starts by filling the whole query store
    first_random = n_pushed;
    for (int k = 0; k < MAX_QUERY; k++) add_request(CMD_LOAD, ROW_W'(k), pick_base(), 1'b0);

    // match 15, mismatch and gap -15, zero threshold, full query
    settle();
    write_reg(REG_MATCH, 15);
    write_reg(REG_MISMATCH, -15);
    write_reg(REG_GAP, -15);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_QLEN, MAX_QUERY);
    add_job(5);

    // other extremes: no reward, no penalty, jumps hardly ever pay
    settle();
    write_reg(REG_MATCH, 0);
    write_reg(REG_MISMATCH, 0);
    write_reg(REG_GAP, 0);
    write_reg(REG_THRESHOLD, 255);
    write_reg(REG_QLEN, 1);
    add_job(10);
    add_job(10);

    // random settings, mostly short queries
    while (n_pushed < first_random + RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       qlen = $urandom_range(41, MAX_QUERY);
        1, 2:    qlen = $urandom_range(13, 40);
        3:       qlen = 0;
        default: qlen = $urandom_range(1, 12);
      endcase
      write_reg(REG_MATCH, $urandom_range(0, 15));
      write_reg(REG_MISMATCH, -int'($urandom_range(0, 15)));
      write_reg(REG_GAP, -int'($urandom_range(0, 15)));
      write_reg(REG_THRESHOLD, $urandom_range(0, 1) ? $urandom_range(0, 24) :
                                                     $urandom_range(0, 255));
      write_reg(REG_QLEN, qlen);
      repeat ($urandom_range(1, 3)) begin
        steps = (qlen > 40) ? $urandom_range(2, 5) : $urandom_range(4, 20);
        add_job(steps);
      end
    end

    // closing part without idling: back to back reference steps, then a restart and more steps
    calm = 1'b1;
    settle();
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_QLEN, 3);
    add_request(CMD_START, 6'd0, 8'h00, 1'b0);
    repeat (20) add_request(CMD_STEP, ROW_W'($urandom), pick_base(), 1'b0);
    add_request(CMD_START, 6'd63, 8'hFF, 1'b0);
    repeat (3) add_request(CMD_STEP, ROW_W'($urandom), pick_base(), 1'b0);
    settle();

    // late cells would show up here
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("%0d requests: %0d reference steps (%0d past the column limit),",
             n_accepted, n_steps, n_dropped);
    $display("  %0d loads, %0d starts, %0d unused codes; %0d cells checked (%0d jump, %0d left)",
             n_loads, n_starts, n_unused, n_cells, n_jumps, n_lefts);
    $display("%0d register writes", n_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
